[sv/qfe_pkg.sv]
`timescale 1ns / 1ps
package qfe_pkg;

   // datapath widths
   localparam int RAD_W  = 128;  // radicand
   localparam int ROOT_W = 64;   // square root, one bit per cell
   localparam int SREM_W = 66;   // root remainder, at most 2*root
   localparam int NUM_W  = 96;   // dividend, one quotient bit per cell
   localparam int DVS_W  = 66;   // divisor, up to a + 2*root

   // register slices around the two cell rows: input, products, sums,
   // radicand, divider setup and output
   localparam int LATENCY = 6 + ROOT_W + NUM_W;

   // configuration register indexes
   localparam logic [1:0] CSR_LINEAR    = 2'd0;
   localparam logic [1:0] CSR_QUADRATIC = 2'd1;
   localparam logic [1:0] CSR_DP_MIN    = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SATURATED = 2'd1;
   localparam logic [1:0] STATUS_NO_COEFF  = 2'd2;

   typedef enum logic [1:0] {
      MODE_LIN  = 2'd0,
      MODE_QUAD = 2'd1,
      MODE_GEN  = 2'd2,
      MODE_ZERO = 2'd3
   } mode_type;

   // per-item data that rides along the cell rows
   typedef struct packed {
      logic        neg;
      logic        below;
      logic        zero_root;
      mode_type    mode;
      logic [31:0] rho;
      logic [63:0] rd;
   } side_type;

   // one restoring-division lane
   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [DVS_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
      logic [DVS_W-1:0]  dvs;
   } lane_type;

endpackage

[sv/qfe_sqrt_cell.sv]
`timescale 1ns / 1ps
module qfe_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_in,
   input  qfe_pkg::side_type           side_in,
   input  logic [qfe_pkg::RAD_W-1:0]   rad_in,
   input  logic [qfe_pkg::SREM_W-1:0]  rem_in,
   input  logic [qfe_pkg::ROOT_W-1:0]  root_in,
   output logic                        valid_out,
   output qfe_pkg::side_type           side_out,
   output logic [qfe_pkg::RAD_W-1:0]   rad_out,
   output logic [qfe_pkg::SREM_W-1:0]  rem_out,
   output logic [qfe_pkg::ROOT_W-1:0]  root_out
);

   logic                        valid_ff;
   qfe_pkg::side_type           side_ff;
   logic [qfe_pkg::RAD_W-1:0]   rad_ff;
   logic [qfe_pkg::SREM_W-1:0]  rem_ff, rem_next_in;
   logic [qfe_pkg::ROOT_W-1:0]  root_ff, root_next_in;
   logic [qfe_pkg::SREM_W+1:0]  shifted, trial;

   // one root digit: bring in two radicand bits, try root*4+1
   always_comb begin
      shifted = {rem_in, rad_in[qfe_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_in, 2'b01};
      if (shifted >= trial) begin
         rem_next_in  = qfe_pkg::SREM_W'(shifted - trial);
         root_next_in = {root_in[qfe_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_next_in  = qfe_pkg::SREM_W'(shifted);
         root_next_in = {root_in[qfe_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      side_ff <= side_in;
      rad_ff  <= {rad_in[qfe_pkg::RAD_W-3:0], 2'b00};
      rem_ff  <= rem_next_in;
      root_ff <= root_next_in;
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

[sv/qfe_div_cell.sv]
`timescale 1ns / 1ps
module qfe_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_in,
   input  qfe_pkg::side_type  side_in,
   input  qfe_pkg::lane_type  der_in,
   input  qfe_pkg::lane_type  flow_in,
   output logic               valid_out,
   output qfe_pkg::side_type  side_out,
   output qfe_pkg::lane_type  der_out,
   output qfe_pkg::lane_type  flow_out
);

   logic               valid_ff;
   qfe_pkg::side_type  side_ff;
   qfe_pkg::lane_type  der_ff, der_next_in;
   qfe_pkg::lane_type  flow_ff, flow_next_in;

   // one quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic qfe_pkg::lane_type div_step(input qfe_pkg::lane_type l);
      logic [qfe_pkg::DVS_W:0] r2;
      qfe_pkg::lane_type       o;
      r2    = {l.rem, l.num[qfe_pkg::NUM_W-1]};
      o     = l;
      o.num = {l.num[qfe_pkg::NUM_W-2:0], 1'b0};
      if (r2 >= {1'b0, l.dvs}) begin
         o.rem = qfe_pkg::DVS_W'(r2 - {1'b0, l.dvs});
         o.quo = {l.quo[qfe_pkg::NUM_W-2:0], 1'b1};
      end else begin
         o.rem = qfe_pkg::DVS_W'(r2);
         o.quo = {l.quo[qfe_pkg::NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      der_next_in  = div_step(der_in);
      flow_next_in = div_step(flow_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      side_ff <= side_in;
      der_ff  <= der_next_in;
      flow_ff <= flow_next_in;
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign der_out   = der_ff;
   assign flow_out  = flow_ff;

endmodule

[sv/quadratic_flow_element_top.sv]
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   req_delta_p, req_density                start & !busy
// response  rsp_mass_flow, rsp_flow_derivative,     rsp_valid, one cycle
//           rsp_status
// config    csr_index, csr_data                     csr_write
//
// One item enters every cycle; busy is high only while reset is held.
// Each item passes six register slices, a row of 64 square-root
// cells (one root bit each) and a row of 96 divider cells (one quotient bit
// each, derivative and flow side by side).
// Synchronous reset clears the valid bits in every slice; the registers
// return to a = 1.0, b = 0, dp_min = 1 raw.
// The receiver cannot stall.
module quadratic_flow_element_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [31:0]  req_delta_p,
   input  logic [31:0]  req_density,
   output logic         rsp_valid,
   output logic [63:0]  rsp_mass_flow,
   output logic [63:0]  rsp_flow_derivative,
   output logic [1:0]   rsp_status,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int RW = qfe_pkg::ROOT_W;
   localparam int NW = qfe_pkg::NUM_W;

   logic [63:0] lin_ff, quad_ff;
   logic [31:0] dpmin_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff   <= 64'h0000_0001_0000_0000;
         quad_ff  <= 64'd0;
         dpmin_ff <= 32'd1;
      end else if (csr_write) begin
         case (csr_index)
            qfe_pkg::CSR_LINEAR:    lin_ff   <= csr_data;
            qfe_pkg::CSR_QUADRATIC: quad_ff  <= csr_data;
            qfe_pkg::CSR_DP_MIN:    dpmin_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // no item is taken while reset is held
   assign busy = reset;

   // slice 0: input register
   logic        v0_ff;
   logic [31:0] dp0_ff, rho0_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      dp0_ff  <= req_delta_p;
      rho0_ff <= req_density;
   end

   // classify the item
   logic              neg0, below0, a_zero, b_zero;
   logic [31:0]       d0, y0;
   qfe_pkg::mode_type mode0;
   qfe_pkg::side_type side0_in;
   always_comb begin
      neg0   = dp0_ff[31];
      d0     = neg0 ? 32'(-dp0_ff) : dp0_ff;
      below0 = d0 < dpmin_ff;
      a_zero = lin_ff == 64'd0;
      b_zero = quad_ff == 64'd0;
      if (a_zero && b_zero) begin
         mode0 = qfe_pkg::MODE_ZERO;
      end else if ((below0 && !a_zero) || (!below0 && b_zero)) begin
         mode0 = qfe_pkg::MODE_LIN;
      end else if (a_zero) begin
         mode0 = qfe_pkg::MODE_QUAD;
      end else begin
         mode0 = qfe_pkg::MODE_GEN;
      end
      y0 = (mode0 == qfe_pkg::MODE_QUAD && below0) ? dpmin_ff : d0;
      side0_in.neg       = neg0;
      side0_in.below     = below0;
      side0_in.zero_root = (mode0 == qfe_pkg::MODE_QUAD) && !below0 && (d0 == 32'd0);
      side0_in.mode      = mode0;
      side0_in.rho       = rho0_ff;
      side0_in.rd        = rho0_ff * d0;
   end

   // slice 1: 32x32 partial products
   logic              v1_ff;
   qfe_pkg::side_type side1_ff;
   logic [63:0]       p_bl_ff, p_bh_ff, p_ll_ff, p_lh_ff, p_hh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      side1_ff <= side0_in;
      p_bl_ff  <= quad_ff[31:0] * y0;
      p_bh_ff  <= quad_ff[63:32] * y0;
      p_ll_ff  <= lin_ff[31:0] * lin_ff[31:0];
      p_lh_ff  <= lin_ff[31:0] * lin_ff[63:32];
      p_hh_ff  <= lin_ff[63:32] * lin_ff[63:32];
   end

   // slice 2: b*X and a*a
   logic              v2_ff;
   qfe_pkg::side_type side2_ff;
   logic [95:0]       by_ff;
   logic [127:0]      asq_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      side2_ff <= side1_ff;
      by_ff    <= {32'd0, p_bl_ff} + {p_bh_ff, 32'd0};
      asq_ff   <= {64'd0, p_ll_ff} + {31'd0, p_lh_ff, 33'd0} + {p_hh_ff, 64'd0};
   end

   // slice 3: radicand
   logic              v3_ff;
   qfe_pkg::side_type side3_ff;
   logic [127:0]      rad_ff, rad_in;
   always_comb begin
      case (side2_ff.mode)
         qfe_pkg::MODE_QUAD: rad_in = {2'b00, by_ff, 30'd0};
         qfe_pkg::MODE_GEN:  rad_in = {2'b00, asq_ff[127:2]}
                                    + {127'd0, |asq_ff[1:0]}
                                    + {16'd0, by_ff, 16'd0};
         default:            rad_in = 128'd0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      side3_ff <= side2_ff;
      rad_ff   <= rad_in;
   end

   // square-root cell row
   logic                       sq_v    [0:RW];
   qfe_pkg::side_type          sq_side [0:RW];
   logic [qfe_pkg::RAD_W-1:0]  sq_rad  [0:RW];
   logic [qfe_pkg::SREM_W-1:0] sq_rem  [0:RW];
   logic [RW-1:0]              sq_root [0:RW];
   assign sq_v[0]    = v3_ff;
   assign sq_side[0] = side3_ff;
   assign sq_rad[0]  = rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      qfe_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (sq_v[i]),
         .side_in   (sq_side[i]),
         .rad_in    (sq_rad[i]),
         .rem_in    (sq_rem[i]),
         .root_in   (sq_root[i]),
         .valid_out (sq_v[i+1]),
         .side_out  (sq_side[i+1]),
         .rad_out   (sq_rad[i+1]),
         .rem_out   (sq_rem[i+1]),
         .root_out  (sq_root[i+1])
      );
   end

   // slice 4: dividends and divisors
   logic              v4_ff;
   qfe_pkg::side_type side4_ff, sq_s;
   qfe_pkg::lane_type der4_ff, flow4_ff, der4_in, flow4_in;
   logic [RW-1:0]     root;
   always_comb begin
      sq_s = sq_side[RW];
      root = sq_root[RW];
      der4_in  = '0;
      flow4_in = '0;
      case (sq_s.mode)
         qfe_pkg::MODE_LIN: begin
            der4_in.num  = {24'd0, sq_s.rho, 40'd0};
            flow4_in.num = {8'd0, sq_s.rd, 24'd0};
            der4_in.dvs  = {2'b00, lin_ff};
            flow4_in.dvs = {2'b00, lin_ff};
         end
         qfe_pkg::MODE_QUAD: begin
            der4_in.num  = sq_s.below ? {17'd0, sq_s.rho, 47'd0}
                                      : {18'd0, sq_s.rho, 46'd0};
            flow4_in.num = {1'b0, sq_s.rd, 31'd0};
            der4_in.dvs  = sq_s.zero_root ? 66'd1 : {2'b00, root};
            flow4_in.dvs = der4_in.dvs;
         end
         qfe_pkg::MODE_GEN: begin
            der4_in.num  = {23'd0, sq_s.rho, 41'd0};
            flow4_in.num = {7'd0, sq_s.rd, 25'd0};
            der4_in.dvs  = {1'b0, root, 1'b0};
            flow4_in.dvs = {2'b00, lin_ff} + {1'b0, root, 1'b0};
         end
         default: begin
            der4_in.dvs  = 66'd1;
            flow4_in.dvs = 66'd1;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= sq_v[RW];
      end
      side4_ff <= sq_s;
      der4_ff  <= der4_in;
      flow4_ff <= flow4_in;
   end

   // divider cell row
   logic              dv_v    [0:NW];
   qfe_pkg::side_type dv_side [0:NW];
   qfe_pkg::lane_type dv_der  [0:NW];
   qfe_pkg::lane_type dv_flow [0:NW];
   assign dv_v[0]    = v4_ff;
   assign dv_side[0] = side4_ff;
   assign dv_der[0]  = der4_ff;
   assign dv_flow[0] = flow4_ff;
   for (genvar j = 0; j < NW; j++) begin : g_div
      qfe_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (dv_v[j]),
         .side_in   (dv_side[j]),
         .der_in    (dv_der[j]),
         .flow_in   (dv_flow[j]),
         .valid_out (dv_v[j+1]),
         .side_out  (dv_side[j+1]),
         .der_out   (dv_der[j+1]),
         .flow_out  (dv_flow[j+1])
      );
   end

   // saturation, sign and output register
   qfe_pkg::side_type dv_s;
   logic [NW-1:0]     dq, fq;
   logic [63:0]       limit, flow, dv, flow_in, dv_in;
   logic [1:0]        status_in;
   always_comb begin
      dv_s      = dv_side[NW];
      dq        = dv_der[NW].quo;
      fq        = dv_flow[NW].quo;
      status_in = qfe_pkg::STATUS_OK;
      limit     = dv_s.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (|dq[NW-1:64]) begin
         dv        = '1;
         status_in = qfe_pkg::STATUS_SATURATED;
      end else begin
         dv = dq[63:0];
      end
      if ((|fq[NW-1:64]) || (fq[63:0] > limit)) begin
         flow      = limit;
         status_in = qfe_pkg::STATUS_SATURATED;
      end else begin
         flow = fq[63:0];
      end
      flow_in = dv_s.neg ? 64'(-flow) : flow;
      dv_in   = dv;
      if (dv_s.mode == qfe_pkg::MODE_ZERO) begin
         flow_in   = '0;
         dv_in     = '0;
         status_in = qfe_pkg::STATUS_NO_COEFF;
      end else if (dv_s.zero_root) begin
         flow_in   = '0;
         dv_in     = '1;
         status_in = qfe_pkg::STATUS_SATURATED;
      end
   end

   logic        out_v_ff;
   logic [63:0] flow_ff, dv_ff;
   logic [1:0]  status_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= dv_v[NW];
      end
      flow_ff   <= flow_in;
      dv_ff     <= dv_in;
      status_ff <= status_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_mass_flow       = flow_ff;
   assign rsp_flow_derivative = dv_ff;
   assign rsp_status          = status_ff;

endmodule

[sv/qfe_checker.sv]
`timescale 1ns / 1ps
module qfe_checker (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic [31:0]  req_delta_p,
   input logic         rsp_valid,
   input logic [63:0]  rsp_mass_flow,
   input logic [63:0]  rsp_flow_derivative,
   input logic [1:0]   rsp_status
);

   // every result comes from an item taken with start high and busy low
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, qfe_pkg::LATENCY))
      else $error("result without matching item");

   // no coefficients gives an all-zero result
   a_no_coeff: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == qfe_pkg::STATUS_NO_COEFF)
         |-> (rsp_mass_flow == 64'd0 && rsp_flow_derivative == 64'd0))
      else $error("no-coefficient result not zero");

   // status code is one of the three defined
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == qfe_pkg::STATUS_OK
                     || rsp_status == qfe_pkg::STATUS_SATURATED
                     || rsp_status == qfe_pkg::STATUS_NO_COEFF))
      else $error("undefined status");

   // non-negative pressure never yields a negative flow
   a_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_delta_p[31], qfe_pkg::LATENCY)) |-> !rsp_mass_flow[63])
      else $error("flow sign wrong");

endmodule

bind quadratic_flow_element_top qfe_checker u_qfe_checker (.*);
